// ===== hw/rtl/etce_pkg.sv =====
// Package for the export table column extractor.
// Request and response payload types, parser state type and character constants.
// No dependencies.
`default_nettype none

package etce_pkg;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_A     = 8'h41;

   localparam logic [2:0] KW_NONE = 3'd0;
   localparam logic [2:0] KW_R    = 3'd1;
   localparam logic [2:0] KW_RV   = 3'd2;
   localparam logic [2:0] KW_RVA  = 3'd3;
   localparam logic [2:0] KW_MISS = 3'd4;

   localparam logic [2:0] FIELD_KEYWORD = 3'd3;
   localparam logic [2:0] FIELD_SYMBOL  = 3'd4;
   localparam logic [2:0] FIELD_MAX     = 3'd7;

   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic       active_mode;
      logic       skip_line;
      logic [2:0] field_number;
      logic       inside_field;
      logic [2:0] keyword_match;
      logic       fourth_field_seen;
   } state_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] res_byte;
      logic [1:0]                  count;
   } burst_type;

endpackage

`default_nettype wire

// ===== hw/rtl/etce_parse.sv =====
// Per-byte parser step: next line state and the burst of bytes that one request gives.
// Purely combinational; depends on etce_pkg.
`default_nettype none

module etce_parse (
   input  wire etce_pkg::state_type st,
   input  wire etce_pkg::req_type   req,
   output etce_pkg::state_type      st_next,
   output etce_pkg::burst_type      burst
);
   import etce_pkg::*;

   logic      space;
   logic      emit_byte;
   logic      emit_crlf;
   state_type s;

   assign space = (req.in_byte == CHAR_TAB) || (req.in_byte == CHAR_LF) ||
                  (req.in_byte == CHAR_CR) || (req.in_byte == CHAR_SPACE);

   always_comb begin
      s         = st;
      emit_byte = 1'b0;
      emit_crlf = 1'b0;
      if (s.skip_line) begin
         if (req.in_byte == CHAR_LF) begin
            s.skip_line         = 1'b0;
            s.field_number      = '0;
            s.inside_field      = 1'b0;
            s.keyword_match     = KW_NONE;
            s.fourth_field_seen = 1'b0;
         end
      end else begin
         if (!space) begin
            if (!s.inside_field) begin
               s.inside_field = 1'b1;
               if (s.field_number < FIELD_MAX) begin
                  s.field_number = s.field_number + 3'd1;
               end
            end
            if (s.field_number == FIELD_KEYWORD) begin
               if (s.keyword_match == KW_NONE && req.in_byte == CHAR_R) begin
                  s.keyword_match = KW_R;
               end else if (s.keyword_match == KW_R && req.in_byte == CHAR_V) begin
                  s.keyword_match = KW_RV;
               end else if (s.keyword_match == KW_RV && req.in_byte == CHAR_A) begin
                  s.keyword_match = KW_RVA;
               end else begin
                  s.keyword_match = KW_MISS;
               end
            end
            if (s.field_number == FIELD_SYMBOL && s.active_mode) begin
               emit_byte           = 1'b1;
               s.fourth_field_seen = 1'b1;
            end
         end else begin
            if (s.inside_field && s.field_number == FIELD_SYMBOL && s.active_mode) begin
               emit_crlf = 1'b1;
            end
            s.inside_field = 1'b0;
         end
         if (req.in_byte == CHAR_LF) begin
            if (s.active_mode) begin
               s.active_mode = s.fourth_field_seen;
            end else if (s.keyword_match == KW_RVA) begin
               s.active_mode = 1'b1;
               s.skip_line   = 1'b1;
            end
            s.field_number      = '0;
            s.inside_field      = 1'b0;
            s.keyword_match     = KW_NONE;
            s.fourth_field_seen = 1'b0;
         end
      end
      if (req.end_of_input) begin
         if (!s.skip_line && s.inside_field && s.field_number == FIELD_SYMBOL &&
             s.active_mode) begin
            emit_crlf = 1'b1;
         end
         s = '0;
      end
      st_next = s;
   end

   always_comb begin
      if (emit_byte) begin
         burst.res_byte = {CHAR_LF, CHAR_CR, req.in_byte};
         burst.count    = emit_crlf ? 2'd3 : 2'd1;
      end else begin
         burst.res_byte = {CHAR_LF, CHAR_LF, CHAR_CR};
         burst.count    = emit_crlf ? 2'd2 : 2'd0;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/export_table_column_extractor_unit.sv =====
// Top level of the export table column extractor.
// Holds the parser state and a three-byte response buffer; depends on etce_pkg and etce_parse.
//
//   Channel   Direction  Payload              Handshake
//   req_      in         etce_pkg::req_type   req_valid / req_ready
//   rsp_      out        etce_pkg::rsp_type   rsp_valid / rsp_ready
//
// Each request is parsed in the cycle it is accepted; its responses (none to three) leave
// the buffer one per cycle while rsp_ready is high, from the next cycle on. A request that
// gives no response, or one arriving as the last buffered response is taken, is accepted
// without a gap, so requests of at most one response go one per cycle while rsp_ready is high.
// Reset clears the parser state and empties the buffer. A stalled response holds the
// buffer, and with it the request channel, until it is taken.
`default_nettype none

module export_table_column_extractor_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire etce_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output etce_pkg::rsp_type      rsp_data
);
   import etce_pkg::*;

   state_type                   state_ff;
   state_type                   state_in;
   burst_type                   burst;
   logic [MAX_RESULTS-1:0][7:0] buf_ff;
   logic [1:0]                  cnt_ff;
   logic [1:0]                  cnt_in;
   logic [1:0]                  pos_ff;
   logic [1:0]                  pos_in;
   logic                        req_take;
   logic                        rsp_take;

   etce_parse u_parse (
      .st      (state_ff),
      .req     (req_data),
      .st_next (state_in),
      .burst   (burst)
   );

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_data  = {buf_ff[pos_ff], (cnt_ff == 2'd1)};

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (req_take) begin
         cnt_in = burst.count;
         pos_in = 2'd0;
      end else if (rsp_take) begin
         cnt_in = cnt_ff - 2'd1;
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= 2'd0;
         pos_ff   <= 2'd0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         buf_ff <= burst.res_byte;
      end
   end

endmodule

`default_nettype wire

// ===== dv/export_table_column_extractor_unit_tb.sv =====
// Self-checking testbench for export_table_column_extractor_unit: directed rows, then random lines.
// Expected symbol bytes come from a testbench line parser or a typed row; depends on etce_pkg.
// Self-contained; needs only the RTL of the block and its package.
`default_nettype none

module export_table_column_extractor_unit_tb;

   import etce_pkg::*;

   localparam int PER_PHASE    = 70;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [7:0]      text;
      logic            eoi;
      logic            typed;
      logic [1:0]      count;
      logic [2:0][7:0] col;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   logic       line_active;
   logic       line_skip;
   logic [2:0] field_count;
   logic       in_field;
   logic [2:0] kw_state;
   logic       symbol_seen;

   rsp_type      expected_symbols[$];
   stim_row_type directed_rows[26];
   int           items_sent;
   int           symbols_predicted;
   int           fault_count;
   int           cycle_count;
   int           send_idle_pct;
   int           stall_pct;
   int           hold_left;
   logic         hold_off_pending;

   export_table_column_extractor_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic logic is_blank(input logic [7:0] b);
      return b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR || b == CHAR_SPACE;
   endfunction

   function automatic logic [7:0] random_ink();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      while (is_blank(b)) b = 8'($urandom_range(255));
      return b;
   endfunction

   function automatic logic [7:0] random_gap();
      case ($urandom_range(2))
         0: begin
            return CHAR_TAB;
         end
         1: begin
            return CHAR_CR;
         end
         default: begin
            return CHAR_SPACE;
         end
      endcase
   endfunction

   task automatic clear_line_state();
      field_count = '0;
      in_field    = 1'b0;
      kw_state    = KW_NONE;
      symbol_seen = 1'b0;
   endtask

   task automatic restart_extractor();
      line_active = 1'b0;
      line_skip   = 1'b0;
      clear_line_state();
   endtask

   // Works out the symbol bytes that one request yields and advances the parser state.
   task automatic extract_column(input logic [7:0] b, input logic eoi,
                                 output logic [2:0][7:0] col, output int n);
      col = '0;
      n   = 0;
      if (line_skip) begin
         if (b == CHAR_LF) begin
            line_skip = 1'b0;
            clear_line_state();
         end
      end else begin
         if (!is_blank(b)) begin
            if (!in_field) begin
               in_field = 1'b1;
               if (field_count != FIELD_MAX) field_count = field_count + 3'd1;
            end
            if (field_count == FIELD_KEYWORD) begin
               if (kw_state == KW_NONE && b == CHAR_R) kw_state = KW_R;
               else if (kw_state == KW_R && b == CHAR_V) kw_state = KW_RV;
               else if (kw_state == KW_RV && b == CHAR_A) kw_state = KW_RVA;
               else kw_state = KW_MISS;
            end
            if (field_count == FIELD_SYMBOL && line_active) begin
               col[n]      = b;
               n           = n + 1;
               symbol_seen = 1'b1;
            end
         end else begin
            if (in_field && field_count == FIELD_SYMBOL && line_active) begin
               col[n]     = CHAR_CR;
               col[n + 1] = CHAR_LF;
               n          = n + 2;
            end
            in_field = 1'b0;
         end
         if (b == CHAR_LF) begin
            if (line_active) begin
               line_active = symbol_seen;
            end else if (kw_state == KW_RVA) begin
               line_active = 1'b1;
               line_skip   = 1'b1;
            end
            clear_line_state();
         end
      end
      if (eoi) begin
         if (!line_skip && in_field && field_count == FIELD_SYMBOL && line_active) begin
            col[n]     = CHAR_CR;
            col[n + 1] = CHAR_LF;
            n          = n + 2;
         end
         restart_extractor();
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input stim_row_type row);
      logic [2:0][7:0] col;
      int              n;
      rsp_type         want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_data.in_byte      <= row.text;
      req_data.end_of_input <= row.eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      extract_column(row.text, row.eoi, col, n);
      if (row.typed) begin
         col = row.col;
         n   = row.count;
      end
      for (int i = 0; i < n; i++) begin
         want.out_byte    = col[i];
         want.last_of_run = (i == n - 1);
         expected_symbols.push_back(want);
      end
      symbols_predicted = symbols_predicted + n;
      items_sent        = items_sent + 1;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eoi);
      stim_row_type row;
      row       = '0;
      row.text  = b;
      row.eoi   = eoi;
      send_request(row);
   endtask

   task automatic send_random_line();
      logic [7:0] text[$];
      int         fields;
      text = {};
      if ($urandom_range(3) == 0) text.push_back(random_gap());
      fields = ($urandom_range(3) == 0) ? $urandom_range(6) : $urandom_range(4, 5);
      for (int f = 1; f <= fields; f++) begin
         if (f > 1) repeat ($urandom_range(1, 2)) text.push_back(random_gap());
         if (f == 3 && $urandom_range(2) != 0) begin
            case ($urandom_range(5))
               3: begin
                  text.push_back(CHAR_R);
                  text.push_back(CHAR_V);
               end
               4: begin
                  text.push_back(CHAR_R);
                  text.push_back(CHAR_V);
                  text.push_back(CHAR_A);
                  text.push_back(random_ink());
               end
               5: begin
                  text.push_back(CHAR_R);
                  text.push_back(random_ink());
                  text.push_back(CHAR_A);
               end
               default: begin
                  text.push_back(CHAR_R);
                  text.push_back(CHAR_V);
                  text.push_back(CHAR_A);
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 4)) text.push_back(random_ink());
         end
      end
      if ($urandom_range(2) == 0) text.push_back(random_gap());
      text.push_back(CHAR_LF);
      foreach (text[i]) send_byte(text[i], $urandom_range(149) == 0);
   endtask

   task automatic note_fault(input string what, input rsp_type want, input rsp_type got);
      fault_count = fault_count + 1;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s: expected byte %h last %b, got byte %h last %b", $time, what,
                  want.out_byte, want.last_of_run, got.out_byte, got.last_of_run);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("export_table_column_extractor_unit_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_symbols.size() == 0) begin
            note_fault("unexpected response", '0, rsp_data);
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               note_fault("out_byte mismatch", want, rsp_data);
            if (rsp_data.last_of_run !== want.last_of_run)
               note_fault("last_of_run mismatch", want, rsp_data);
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left        = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      int target;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      items_sent        = 0;
      symbols_predicted = 0;
      fault_count       = 0;
      cycle_count       = 0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      hold_left         = 0;
      hold_off_pending  = 1'b0;
      restart_extractor();

      directed_rows = '{
         '{8'h00,      1'b0, 1'b1, 2'd0, 24'h0},
         '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h62,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_TAB,   1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_R,     1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_V,     1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_A,     1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_LF,    1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_LF,    1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h61,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_CR,    1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h62,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h63,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'hFF,      1'b0, 1'b1, 2'd1, {8'h00, 8'h00, 8'hFF}},
         '{CHAR_SPACE, 1'b0, 1'b1, 2'd2, {8'h00, CHAR_LF, CHAR_CR}},
         '{8'h71,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_LF,    1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h61,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h62,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h63,      1'b0, 1'b0, 2'd0, 24'h0},
         '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, 24'h0},
         '{8'h58,      1'b1, 1'b1, 2'd3, {CHAR_LF, CHAR_CR, 8'h58}}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct    = 0;
               stall_pct        = 0;
               hold_off_pending = 1'b1;
            end
            1: begin
               send_idle_pct = 85;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 85;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct     = 35;
            end
         endcase
         target = (p + 1) * PER_PHASE;
         while ((items_sent < target || (p == 3 && symbols_predicted < 60))
                && items_sent < 2000) begin
            if ($urandom_range(7) == 0)
               repeat ($urandom_range(1, 8))
                  send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
            else
               send_random_line();
         end
      end

      req_valid <= 1'b0;
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fault_count == 0 && expected_symbols.size() == 0)
         $display("export_table_column_extractor_unit_tb: clean");
      else
         $display("export_table_column_extractor_unit_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/etce_pkg.sv
hw/rtl/etce_parse.sv
hw/rtl/export_table_column_extractor_unit.sv
dv/export_table_column_extractor_unit_tb.sv
